@@ sv/mpd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_pkg: shared definitions for the matrix peak detector
// Widths, line store geometry, queue sizing, register indexes and the record
// that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package mpd_pkg;

	// Matrix geometry and field widths.
	localparam int MAX_COLUMNS = 1024;
	localparam int RING_ROWS   = 3;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ROW_W       = 16;
	localparam int VAL_W       = 32;
	localparam int SLOT_W      = 2;
	localparam int LS_DEPTH    = RING_ROWS * MAX_COLUMNS;
	localparam int LS_AW       = $clog2(LS_DEPTH);

	// Configuration registers.
	localparam int ROWCNT_W = 16;
	localparam int COLCNT_W = 11;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	// Queue between the front and the back part.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [ROW_W-1:0]        row_t;
	typedef logic [COL_W-1:0]        col_t;
	typedef logic [SLOT_W-1:0]       slot_t;
	typedef logic signed [VAL_W-1:0] val_t;

	// Effective geometry and restart pulse handed to the front part.
	typedef struct packed {
		row_t last_row;
		col_t last_col;
		logic restart;
	} cfg_t;

	// Which judgments a word causes and which neighbours exist.
	typedef struct packed {
		logic j_above;
		logic j_left;
		logic j_here;
		logic has_up2;
		logic has_up;
		logic has_left;
		logic has_left2;
		logic has_right;
	} jflags_t;

	// One accepted word with all the values its judgments need.
	typedef struct packed {
		row_t    row;
		col_t    col;
		jflags_t fl;
		val_t    v;
		val_t    cur_m1;
		val_t    cur_m2;
		val_t    prev_m1;
		val_t    prev_0;
		val_t    prev_p1;
		val_t    up2;
	} job_t;

endpackage
`default_nettype wire

@@ sv/mpd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_front: input side of the matrix peak detector
// Accepts one word per cycle while the queue has room, tracks its row,
// column and ring slot, writes it to the three-row line store and reads the
// neighbours it needs; the complete record enters the queue in the next cycle.
// ----------------------------------------------------------------------------
module mpd_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mpd_pkg::cfg_t   cfg,
	input  wire logic            element_valid,
	output logic                 element_ready,
	input  wire mpd_pkg::val_t   element_value,
	output logic                 q_push,
	output mpd_pkg::job_t        q_push_data,
	input  wire logic [mpd_pkg::QCNT_W-1:0] q_count
);

	// Line store: one row per ring slot, addressed {slot, column}.
	mpd_pkg::val_t line_mem [0:mpd_pkg::LS_DEPTH-1];

	// Input position.
	mpd_pkg::row_t  row_q;
	mpd_pkg::col_t  col_q;
	mpd_pkg::slot_t slot_q;

	// Last two words of the current row and a window over the row above.
	mpd_pkg::val_t cur_m1_q;
	mpd_pkg::val_t cur_m2_q;
	mpd_pkg::val_t win_lo_q;
	mpd_pkg::val_t win_mid_q;

	// Stage one: memory read data and the accepted word.
	logic              valid_s1;
	mpd_pkg::row_t     row_s1;
	mpd_pkg::col_t     col_s1;
	mpd_pkg::jflags_t  fl_s1;
	mpd_pkg::val_t     v_s1;
	mpd_pkg::val_t     cur_m1_s1;
	mpd_pkg::val_t     cur_m2_s1;
	mpd_pkg::val_t     rd_a_s1;
	mpd_pkg::val_t     rd_b_s1;
	logic              row_end_s1;
	logic              fwd_s1;

	logic                      accept;
	logic                      c_end;
	logic                      r_end;
	mpd_pkg::slot_t            prev_slot;
	mpd_pkg::slot_t            up2_slot;
	mpd_pkg::col_t             col_inc;
	logic [mpd_pkg::LS_AW-1:0] addr_a;
	logic [mpd_pkg::LS_AW-1:0] addr_b;
	logic [mpd_pkg::LS_AW-1:0] waddr;
	mpd_pkg::jflags_t          fl_in;

	// Room is reserved in the queue for the word in stage one and a new one.
	assign element_ready = (q_count + mpd_pkg::QCNT_W'(valid_s1))
		< mpd_pkg::QCNT_W'(mpd_pkg::QUEUE_DEPTH);
	assign accept = element_valid & element_ready;

	// Position decode and ring slot neighbours.
	always_comb begin
		c_end     = (col_q == cfg.last_col);
		r_end     = (row_q == cfg.last_row);
		prev_slot = (slot_q == '0) ? mpd_pkg::SLOT_W'(2) : slot_q - 1'b1;
		up2_slot  = (slot_q == mpd_pkg::SLOT_W'(2)) ? '0 : slot_q + 1'b1;
		col_inc   = col_q + 1'b1;
	end

	// Port A reads the row above one column ahead; at the end of a row it
	// fetches column zero of this row, which is the next row's upper row.
	always_comb begin
		addr_a = c_end ? {slot_q, mpd_pkg::COL_W'(0)} : {prev_slot, col_inc};
		addr_b = {up2_slot, col_q};
		waddr  = {slot_q, col_q};
	end

	// Judgments caused by this word and the neighbours that exist.
	always_comb begin
		fl_in.j_above   = (row_q != '0);
		fl_in.j_left    = r_end && (col_q != '0);
		fl_in.j_here    = r_end && c_end;
		fl_in.has_up2   = (row_q[mpd_pkg::ROW_W-1:1] != '0);
		fl_in.has_up    = (row_q != '0);
		fl_in.has_left  = (col_q != '0);
		fl_in.has_left2 = (col_q[mpd_pkg::COL_W-1:1] != '0);
		fl_in.has_right = !c_end;
	end

	// Line store write and registered reads.
	always_ff @(posedge clk) begin
		if (accept) begin
			line_mem[waddr] <= element_value;
			rd_a_s1         <= line_mem[addr_a];
			rd_b_s1         <= line_mem[addr_b];
		end
	end

	// Position counters and stage one valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
			slot_q   <= '0;
		end else begin
			valid_s1 <= accept;
			if (cfg.restart) begin
				row_q  <= '0;
				col_q  <= '0;
				slot_q <= '0;
			end else if (accept) begin
				if (c_end) begin
					col_q <= '0;
					if (r_end) begin
						row_q  <= '0;
						slot_q <= '0;
					end else begin
						row_q  <= row_q + 1'b1;
						slot_q <= up2_slot;
					end
				end else begin
					col_q <= col_inc;
				end
			end
		end
	end

	// Stage one payload and the current row history.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1     <= row_q;
			col_s1     <= col_q;
			fl_s1      <= fl_in;
			v_s1       <= element_value;
			cur_m1_s1  <= cur_m1_q;
			cur_m2_s1  <= cur_m2_q;
			row_end_s1 <= c_end;
			fwd_s1     <= (cfg.last_col == '0);
			cur_m1_q   <= element_value;
			cur_m2_q   <= cur_m1_q;
		end
	end

	// Slide the upper row window; a one-column matrix takes the word itself.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			win_lo_q  <= win_mid_q;
			win_mid_q <= (row_end_s1 && fwd_s1) ? v_s1 : rd_a_s1;
		end
	end

	// Record pushed into the queue.
	always_comb begin
		q_push              = valid_s1;
		q_push_data.row     = row_s1;
		q_push_data.col     = col_s1;
		q_push_data.fl      = fl_s1;
		q_push_data.v       = v_s1;
		q_push_data.cur_m1  = cur_m1_s1;
		q_push_data.cur_m2  = cur_m2_s1;
		q_push_data.prev_m1 = win_lo_q;
		q_push_data.prev_0  = win_mid_q;
		q_push_data.prev_p1 = rd_a_s1;
		q_push_data.up2     = rd_b_s1;
	end

`ifndef NO_ASSERTIONS
	// The queue always has room for the word leaving stage one.
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (q_count < mpd_pkg::QCNT_W'(mpd_pkg::QUEUE_DEPTH)))
		else $error("front pushes into a full queue");

	// The final word of a matrix returns the position to the origin.
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && c_end && r_end) |=> (row_q == '0 && col_q == '0 && slot_q == '0))
		else $error("position did not wrap after the last word");
`endif

endmodule
`default_nettype wire

@@ sv/mpd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_queue: short queue between the front and the back part
// Holds records of accepted words so that the input side keeps running
// while the result side is stalled or busy with several results.
// ----------------------------------------------------------------------------
module mpd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mpd_pkg::job_t   push_data,
	input  wire logic            pop,
	output logic                 head_valid,
	output mpd_pkg::job_t        head_data,
	output logic [mpd_pkg::QCNT_W-1:0] count
);

	mpd_pkg::job_t               entries_q [0:mpd_pkg::QUEUE_DEPTH-1];
	logic [mpd_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [mpd_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [mpd_pkg::QCNT_W-1:0]  count_q;

	assign head_valid = (count_q != '0);
	assign head_data  = entries_q[rd_ptr_q];
	assign count      = count_q;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// No pop from an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue popped while empty");

	// No push into a full queue without a pop in the same cycle.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (count_q < mpd_pkg::QCNT_W'(mpd_pkg::QUEUE_DEPTH)))
		else $error("queue pushed while full");
`endif

endmodule
`default_nettype wire

@@ sv/mpd_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpd_back: result side of the matrix peak detector
// Takes the record at the head of the queue and issues its judgments one
// per cycle while the output is free (upper row first, then left and
// current element on the last row) into the output register.
// ----------------------------------------------------------------------------
module mpd_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire mpd_pkg::job_t   head,
	output logic                 pop,
	output logic                 result_valid,
	input  wire logic            result_ready,
	output mpd_pkg::row_t        judged_row,
	output mpd_pkg::col_t        judged_column,
	output mpd_pkg::val_t        judged_value,
	output logic                 is_peak,
	output logic                 last_of_matrix
);

	// One-hot judgment selects.
	localparam logic [2:0] SEL_ABOVE = 3'b001;
	localparam logic [2:0] SEL_LEFT  = 3'b010;
	localparam logic [2:0] SEL_HERE  = 3'b100;

	logic [2:0]    done_q;
	logic          result_valid_q;
	mpd_pkg::row_t row_q;
	mpd_pkg::col_t col_q;
	mpd_pkg::val_t value_q;
	logic          peak_q;
	logic          last_q;

	logic [2:0]    pend;
	logic [2:0]    sel;
	logic [2:0]    rest;
	logic          can_out;
	logic          emit;

	mpd_pkg::row_t j_row;
	mpd_pkg::col_t j_col;
	mpd_pkg::val_t j_val;
	mpd_pkg::val_t n_up;
	mpd_pkg::val_t n_dn;
	mpd_pkg::val_t n_lf;
	mpd_pkg::val_t n_rt;
	logic          e_up;
	logic          e_dn;
	logic          e_lf;
	logic          e_rt;
	logic          j_last;
	logic          j_peak;

	// Pick the next judgment still owed for the head record.
	always_comb begin
		pend    = {head.fl.j_here, head.fl.j_left, head.fl.j_above} & ~done_q;
		sel     = pend & (~pend + 3'd1);
		rest    = pend & ~sel;
		can_out = !result_valid_q || result_ready;
		emit    = head_valid && (pend != '0) && can_out;
		pop     = head_valid && ((pend == '0) || (can_out && (rest == '0)));
	end

	// Element and neighbours of the selected judgment.
	always_comb begin
		j_row  = head.row;
		j_col  = head.col;
		j_val  = head.v;
		n_up   = head.prev_0;
		n_dn   = head.v;
		n_lf   = head.cur_m1;
		n_rt   = head.v;
		e_up   = 1'b0;
		e_dn   = 1'b0;
		e_lf   = 1'b0;
		e_rt   = 1'b0;
		j_last = 1'b0;
		case (sel)
			SEL_ABOVE: begin
				j_row = head.row - 1'b1;
				j_val = head.prev_0;
				n_up  = head.up2;
				n_dn  = head.v;
				n_lf  = head.prev_m1;
				n_rt  = head.prev_p1;
				e_up  = head.fl.has_up2;
				e_dn  = 1'b1;
				e_lf  = head.fl.has_left;
				e_rt  = head.fl.has_right;
			end
			SEL_LEFT: begin
				j_col = head.col - 1'b1;
				j_val = head.cur_m1;
				n_up  = head.prev_m1;
				n_lf  = head.cur_m2;
				n_rt  = head.v;
				e_up  = head.fl.has_up;
				e_lf  = head.fl.has_left2;
				e_rt  = 1'b1;
			end
			SEL_HERE: begin
				j_val  = head.v;
				n_up   = head.prev_0;
				n_lf   = head.cur_m1;
				e_up   = head.fl.has_up;
				e_lf   = head.fl.has_left;
				j_last = 1'b1;
			end
			default: begin
				j_last = 1'b0;
			end
		endcase
		j_peak = !((e_up && (n_up > j_val)) || (e_dn && (n_dn > j_val)) ||
			(e_lf && (n_lf > j_val)) || (e_rt && (n_rt > j_val)));
	end

	// Judgment progress and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				done_q <= '0;
			end else if (emit) begin
				done_q <= done_q | sel;
			end
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (emit) begin
			row_q   <= j_row;
			col_q   <= j_col;
			value_q <= j_val;
			peak_q  <= j_peak;
			last_q  <= j_last;
		end
	end

	assign result_valid   = result_valid_q;
	assign judged_row     = row_q;
	assign judged_column  = col_q;
	assign judged_value   = value_q;
	assign is_peak        = peak_q;
	assign last_of_matrix = last_q;

`ifndef NO_ASSERTIONS
	// Partial progress exists only for a record that is still at the head.
	a_done_head: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q != '0) |-> head_valid)
		else $error("judgment progress without a head record");

	// Exactly one judgment is issued per output word.
	a_one_sel: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> $onehot(sel))
		else $error("judgment select not one-hot");

	// A record with nothing left to judge leaves the queue at once.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && (pend == '0)) |-> pop)
		else $error("finished record not popped");
`endif

endmodule
`default_nettype wire

@@ sv/matrix_peak_detector.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_peak_detector: four-neighbour local maximum finder
// Streams a matrix in raster order and flags each element that no existing
// up, down, left or right neighbour exceeds.
// ----------------------------------------------------------------------------
// The block takes one element word per cycle while the queue has room and
// returns one result word per cycle while results are taken. Each element is
// judged as soon as its lower and right neighbours have arrived: a word above
// the last row gives at most one result, a word on the last row up to three,
// and the result for the final element carries last_of_matrix. The output port
// issues at most one result a cycle, so on the last row the input slows to the
// rate at which results are taken; elsewhere it runs at one word a cycle while
// results are taken. A first result passes a line store read, the four-entry
// queue and the output register. Rows are kept in a three-row line store of 1024
// columns with one write and two reads per cycle; it needs no clearing after
// reset. Write row_count (address 0) and column_count (address 4) only while the
// block is idle; each write restarts the matrix at row zero, column zero.
// ----------------------------------------------------------------------------
module matrix_peak_detector (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [mpd_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [mpd_pkg::PDATA_W-1:0]   pwdata,
	output logic [mpd_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready,
	input  wire logic                          element_valid,
	output logic                               element_ready,
	input  wire logic signed [31:0]            element_value,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [15:0]                        judged_row,
	output logic [9:0]                         judged_column,
	output logic signed [31:0]                 judged_value,
	output logic                               is_peak,
	output logic                               last_of_matrix
);

	logic [mpd_pkg::ROWCNT_W-1:0] row_count_q;
	logic [mpd_pkg::COLCNT_W-1:0] column_count_q;
	logic                         cfg_wr;
	mpd_pkg::cfg_t                cfg;

	logic                         q_push;
	mpd_pkg::job_t                q_push_data;
	logic                         q_pop;
	logic                         q_head_valid;
	mpd_pkg::job_t                q_head;
	logic [mpd_pkg::QCNT_W-1:0]   q_count;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= mpd_pkg::ROWCNT_W'(1);
			column_count_q <= mpd_pkg::COLCNT_W'(1);
		end else if (cfg_wr) begin
			case (paddr[2])
				mpd_pkg::REG_ROW_COUNT: begin
					row_count_q <= pwdata[mpd_pkg::ROWCNT_W-1:0];
				end
				mpd_pkg::REG_COLUMN_COUNT: begin
					column_count_q <= pwdata[mpd_pkg::COLCNT_W-1:0];
				end
				default: begin
					row_count_q <= row_count_q;
				end
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (paddr[2])
			mpd_pkg::REG_ROW_COUNT: begin
				prdata = mpd_pkg::PDATA_W'(row_count_q);
			end
			mpd_pkg::REG_COLUMN_COUNT: begin
				prdata = mpd_pkg::PDATA_W'(column_count_q);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// Effective last row and column; zero counts act as one and the column
	// count saturates at the line store width.
	always_comb begin
		cfg.last_row = (row_count_q == '0) ? '0 : row_count_q - 1'b1;
		if (column_count_q == '0) begin
			cfg.last_col = '0;
		end else if (column_count_q > mpd_pkg::COLCNT_W'(mpd_pkg::MAX_COLUMNS)) begin
			cfg.last_col = mpd_pkg::COL_W'(mpd_pkg::MAX_COLUMNS - 1);
		end else begin
			cfg.last_col = mpd_pkg::COL_W'(column_count_q - 1'b1);
		end
		cfg.restart = cfg_wr;
	end

	mpd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.element_valid (element_valid),
		.element_ready (element_ready),
		.element_value (element_value),
		.q_push        (q_push),
		.q_push_data   (q_push_data),
		.q_count       (q_count)
	);

	mpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_data  (q_head),
		.count      (q_count)
	);

	mpd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (q_head_valid),
		.head           (q_head),
		.pop            (q_pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.judged_row     (judged_row),
		.judged_column  (judged_column),
		.judged_value   (judged_value),
		.is_peak        (is_peak),
		.last_of_matrix (last_of_matrix)
	);

endmodule
`default_nettype wire
